>>> rtl/srbc_pkg.sv
// Shared types, codes and constants of the sorted record bin chunker.
`default_nettype none

package srbc_pkg;

	localparam int MAX_REFERENCES_DEF = 65536;

	// Result queue depth; must be a power of two and at least two.
	localparam int QUEUE_DEPTH = 4;

	// Records whose bin is at or above this limit are not checked against the reference count when they arrive.
	localparam logic [15:0] LINEAR_BIN_LIMIT = 16'd4681;

	localparam logic FUNC_FLUSH = 1'b1;

	// Register select is paddr[3]: registers lie at byte addresses 0 and 8.
	localparam logic REG_REFERENCE_COUNT = 1'b0;
	localparam logic REG_START_OFFSET    = 1'b1;

	typedef enum logic [2:0] {
		KIND_CHUNK    = 3'd0,
		KIND_UNSORTED = 3'd1,
		KIND_OFFSET   = 3'd2,
		KIND_BAD_REF  = 3'd3,
		KIND_DONE     = 3'd4
	} kind_t;

	typedef struct packed {
		logic               func;
		logic signed [16:0] ref_id;
		logic signed [31:0] position;
		logic [15:0]        bin;
		logic [63:0]        next_offset;
	} item_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] chunk_ref;
		logic [15:0] chunk_bin;
		logic [63:0] chunk_start;
		logic [63:0] chunk_stop;
		logic        last_of_run;
	} result_t;

	// Results produced by one accepted transaction, in order.
	typedef struct packed {
		logic [1:0] count;
		result_t    first;
		result_t    second;
	} push_t;

	typedef struct packed {
		logic        load;
		logic [63:0] value;
	} offset_load_t;

	// A status result carries no chunk and always ends the run of results.
	function automatic result_t status_result(input kind_t k);
		result_t r;
		r = '0;
		r.kind = k;
		r.last_of_run = 1'b1;
		return r;
	endfunction

endpackage

`default_nettype wire

>>> rtl/srbc_if.sv
// Valid/ready channel interfaces for records in and results out.
`default_nettype none

interface srbc_in_if;
	logic               valid;
	logic               ready;
	logic               func;
	logic signed [16:0] ref_id;
	logic signed [31:0] position;
	logic [15:0]        bin;
	logic [63:0]        next_offset;

	modport source(output valid, func, ref_id, position, bin, next_offset, input ready);
	modport sink(input valid, func, ref_id, position, bin, next_offset, output ready);
endinterface

interface srbc_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [15:0] chunk_ref;
	logic [15:0] chunk_bin;
	logic [63:0] chunk_start;
	logic [63:0] chunk_stop;
	logic        last_of_run;

	modport source(output valid, kind, chunk_ref, chunk_bin, chunk_start, chunk_stop,
		last_of_run, input ready);
	modport sink(input valid, kind, chunk_ref, chunk_bin, chunk_start, chunk_stop,
		last_of_run, output ready);
endinterface

`default_nettype wire

>>> rtl/sorted_record_bin_chunker_unit.sv
// Top level of the sorted record bin chunker: register port, run tracker and result queue.
//
// Records arrive on the items channel (valid/ready); a transaction with func set
// is an end-of-input flush. Each accepted record is checked against the run
// state in the cycle it is accepted, and its zero, one or two results enter a
// four-entry queue that drives the results channel; at the earliest they appear in
// the cycle after acceptance. One record is taken every cycle while each gives at most
// one result and the receiver keeps taking results; a record that gives two results
// fills two queue entries, which leave one at a time. The items channel is ready
// whenever the queue has room for two results, so a stalled receiver backs up into
// the queue and then into the sender, and nothing is dropped.
// Errors (unsorted position, offset not increasing, bad reference id) and the
// done result halt the block: later records are taken and give no result.
// Reset clears the run state, the queue and both registers, and halts nothing.
// Registers: reference_count at byte address 0, start_offset at address 8.
// Writing start_offset also reloads the open chunk start and the last offset.
`default_nettype none

module sorted_record_bin_chunker_unit import srbc_pkg::*; #(
	parameter int MAX_REFERENCES = MAX_REFERENCES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	srbc_in_if.sink     items,
	srbc_out_if.source  results,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);

	logic [16:0]  reference_count_q;
	logic [63:0]  start_offset_q;
	logic         cfg_write;
	offset_load_t offset_load;
	item_t        item;
	push_t        push;
	logic         room;
	logic         accept;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reference_count_q <= '0;
			start_offset_q    <= '0;
		end else if (cfg_write) begin
			case (paddr[3])
				REG_REFERENCE_COUNT: reference_count_q <= pwdata[16:0];
				REG_START_OFFSET: start_offset_q <= pwdata;
				default: ;
			endcase
		end
	end

	assign prdata = (paddr[3] == REG_START_OFFSET) ? start_offset_q :
		{47'd0, reference_count_q};

	assign offset_load.load  = cfg_write && (paddr[3] == REG_START_OFFSET);
	assign offset_load.value = pwdata;

	always_comb begin
		item.func        = items.func;
		item.ref_id      = items.ref_id;
		item.position    = items.position;
		item.bin         = items.bin;
		item.next_offset = items.next_offset;
	end

	assign items.ready = room;
	assign accept      = items.valid && room;

	srbc_step #(
		.MAX_REFERENCES(MAX_REFERENCES)
	) u_step (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.item(item),
		.reference_count(reference_count_q),
		.offset_load(offset_load),
		.push(push)
	);

	srbc_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.room(room),
		.res(results)
	);

endmodule

`default_nettype wire

>>> rtl/srbc_step.sv
// Run tracking state and the per-record checks that produce chunks and errors.
`default_nettype none

module srbc_step import srbc_pkg::*; #(
	parameter int MAX_REFERENCES = MAX_REFERENCES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         accept,
	input  item_t        item,
	input  logic [16:0]  reference_count,
	input  offset_load_t offset_load,
	output push_t        push
);

	localparam logic [31:0] MaxRefs = 32'(MAX_REFERENCES);

	logic signed [16:0] current_ref_q;
	logic               open_valid_q;
	logic [15:0]        open_bin_q;
	logic signed [16:0] open_ref_q;
	logic [63:0]        open_start_q;
	logic [63:0]        prev_offset_q;
	logic signed [31:0] prev_pos_q;
	logic               halted_q;

	logic [31:0] ref_limit;
	logic        ref_changed, unsorted, bad_new, bin_diff, close_open, open_ok, off_bad;
	logic        commit, halt;
	result_t     chunk;

	function automatic logic ref_ok(input logic signed [16:0] r, input logic [31:0] lim);
		return !r[16] && ({15'd0, r} < lim);
	endfunction

	assign ref_limit = ({15'd0, reference_count} < MaxRefs) ? {15'd0, reference_count} : MaxRefs;

	// The current bin always equals the open bin, so one register serves both.
	assign ref_changed = item.ref_id != current_ref_q;
	assign unsorted    = !ref_changed && (prev_pos_q > item.position);
	assign bad_new     = !item.ref_id[16] && (item.bin < LINEAR_BIN_LIMIT) &&
		!ref_ok(item.ref_id, ref_limit);
	assign bin_diff    = ref_changed || !open_valid_q || (item.bin != open_bin_q);
	assign close_open  = bin_diff && open_valid_q;
	assign open_ok     = ref_ok(open_ref_q, ref_limit);
	assign off_bad     = item.next_offset <= prev_offset_q;

	always_comb begin
		chunk = '0;
		chunk.kind = KIND_CHUNK;
		chunk.chunk_ref = open_ref_q[15:0];
		chunk.chunk_bin = open_bin_q;
		chunk.chunk_start = open_start_q;
		chunk.chunk_stop = prev_offset_q;
	end

	always_comb begin
		push = '0;
		commit = 1'b0;
		halt = 1'b0;
		if (accept && !halted_q) begin
			if (item.func == FUNC_FLUSH) begin
				halt = 1'b1;
				if (!open_ref_q[16] && !open_ok) begin
					push.count = 2'd1;
					push.first = status_result(KIND_BAD_REF);
				end else if (!open_ref_q[16]) begin
					push.count = 2'd2;
					push.first = chunk;
					push.second = status_result(KIND_DONE);
				end else begin
					push.count = 2'd1;
					push.first = status_result(KIND_DONE);
				end
			end else if (unsorted) begin
				halt = 1'b1;
				push.count = 2'd1;
				push.first = status_result(KIND_UNSORTED);
			end else if (bad_new || (close_open && !open_ok)) begin
				halt = 1'b1;
				push.count = 2'd1;
				push.first = status_result(KIND_BAD_REF);
			end else begin
				if (close_open) begin
					push.count = 2'd1;
					push.first = chunk;
				end
				// An unmapped record opening a run halts with a done result.
				if ((bin_diff && item.ref_id[16]) || off_bad) begin
					halt = 1'b1;
					if (close_open) begin
						push.count = 2'd2;
						push.second = status_result((bin_diff && item.ref_id[16]) ?
							KIND_DONE : KIND_OFFSET);
					end else begin
						push.count = 2'd1;
						push.first = status_result((bin_diff && item.ref_id[16]) ?
							KIND_DONE : KIND_OFFSET);
					end
				end else begin
					commit = 1'b1;
					push.first.last_of_run = close_open;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			current_ref_q <= '1;
			open_valid_q  <= 1'b0;
			open_bin_q    <= '0;
			open_ref_q    <= '1;
			open_start_q  <= '0;
			prev_offset_q <= '0;
			prev_pos_q    <= '1;
			halted_q      <= 1'b0;
		end else begin
			if (offset_load.load) begin
				open_start_q  <= offset_load.value;
				prev_offset_q <= offset_load.value;
			end
			if (halt) begin
				halted_q <= 1'b1;
			end
			if (commit) begin
				current_ref_q <= item.ref_id;
				prev_offset_q <= item.next_offset;
				prev_pos_q    <= item.position;
				if (bin_diff) begin
					open_valid_q <= 1'b1;
					open_bin_q   <= item.bin;
					open_ref_q   <= item.ref_id;
					open_start_q <= prev_offset_q;
				end
			end
		end
	end

	a_halt_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |=> halted_q)
		else $error("halt flag cleared without reset");

	a_halted_silent: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |-> (push.count == 2'd0) && !commit)
		else $error("results or state update while halted");

	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		(push.count == 2'd2) |-> (push.first.kind == KIND_CHUNK) &&
			!push.first.last_of_run && push.second.last_of_run && halt)
		else $error("two results must be a chunk followed by a final status");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		(push.count == 2'd1) |-> push.first.last_of_run)
		else $error("single result not marked last");

endmodule

`default_nettype wire

>>> rtl/srbc_queue.sv
// Result queue that takes up to two results a cycle and delivers one while the receiver is ready.
`default_nettype none

module srbc_queue import srbc_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  push_t             push,
	output logic              room,
	srbc_out_if.source        res
);

	localparam int PtrW = $clog2(DEPTH);
	localparam int CntW = $clog2(DEPTH + 1);

	result_t          mem [DEPTH];
	logic [PtrW-1:0]  wr_q, rd_q;
	logic [CntW-1:0]  count_q;
	logic             pop;
	result_t          head;

	assign pop  = res.valid && res.ready;
	assign room = count_q <= CntW'(DEPTH - 2);
	assign head = mem[rd_q];

	assign res.valid       = count_q != '0;
	assign res.kind        = head.kind;
	assign res.chunk_ref   = head.chunk_ref;
	assign res.chunk_bin   = head.chunk_bin;
	assign res.chunk_start = head.chunk_start;
	assign res.chunk_stop  = head.chunk_stop;
	assign res.last_of_run = head.last_of_run;

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem[wr_q] <= push.first;
		end
		if (push.count == 2'd2) begin
			mem[wr_q + PtrW'(1)] <= push.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + PtrW'(push.count);
			rd_q    <= rd_q + PtrW'(pop);
			count_q <= count_q + CntW'(push.count) - CntW'(pop);
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(DEPTH))
		else $error("result queue overflow");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		(push.count != 2'd0) |-> room)
		else $error("results pushed without room");

	a_empty_stays: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) && (push.count == 2'd0) |=> !res.valid)
		else $error("result appeared without a push");

endmodule

`default_nettype wire
